/* rtl/signed_int_to_decimal_ascii_assert.svh */
// Assertion macros used by the checker of the integer to decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define SITDA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sitda assertion failed");

// Checked on every rising clock edge, reset included.
`define SITDA_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("sitda assertion failed");

`endif

/* rtl/sitda_pkg.sv */
// Constants and conversion functions for the integer to decimal text block.
package sitda_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

	typedef logic [BCD_W-1:0] bcd_t;

	// Eight steps of shift-and-add-3, taking in one byte of the binary value, MSB first.
	function automatic bcd_t dd_step8(input bcd_t bcd_in, input logic [7:0] bits);
		bcd_t bcd;
		bcd = bcd_in;
		for (int i = 0; i < 8; i++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (bcd[4*d +: 4] >= 4'd5)
					bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
			end
			bcd = {bcd[BCD_W-2:0], bits[7-i]};
		end
		return bcd;
	endfunction

	// Index of the most significant nonzero digit; zero when every digit is zero.
	function automatic logic [DIG_IDX_W-1:0] top_digit(input bcd_t bcd);
		logic [DIG_IDX_W-1:0] idx;
		idx = '0;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd[4*d +: 4] != 4'd0)
				idx = DIG_IDX_W'(d);
		end
		return idx;
	endfunction

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII text. A request on the input channel carries
// one two's complement value; its text leaves on the output channel one character per
// request, most significant first, with a leading '-' for negative values and last set
// on the final digit. A request passes through the conversion pipeline (the magnitude is
// formed first, then shift-and-add-3 takes in eight bits at a time) and then occupies
// the single character port for 1 to 11 characters: one per digit, plus one for the
// sign. The character port sets the sustained rate; up to five further requests
// are held in the pipeline while a text is being sent.
module signed_int_to_decimal_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [sitda_pkg::CHAR_W-1:0]  character,
	output logic                                 last
);
	import sitda_pkg::*;

	localparam int unsigned LOW2_W = VALUE_W - 8;
	localparam int unsigned LOW3_W = VALUE_W - 16;
	localparam int unsigned LOW4_W = VALUE_W - 24;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                 free_s1, free_s2, free_s3, free_s4, free_s5;
	logic [VALUE_W-1:0]   mag_s1;
	logic                 neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	bcd_t                 bcd_s2, bcd_s3, bcd_s4, bcd_s5;
	logic [LOW2_W-1:0]    low_s2;
	logic [LOW3_W-1:0]    low_s3;
	logic [LOW4_W-1:0]    low_s4;

	logic                 busy_q, sign_q;
	logic [DIG_IDX_W-1:0] idx_q;
	bcd_t                 digits_q;
	logic                 out_fire, done, emit_free, load;

	assign out_fire  = out_valid && out_ready;
	assign done      = out_fire && !sign_q && (idx_q == '0);
	assign emit_free = !busy_q || done;
	assign load      = v_s5 && emit_free;

	// A stage takes new data when it is empty or its content moves on this cycle.
	assign free_s5  = !v_s5 || emit_free;
	assign free_s4  = !v_s4 || free_s5;
	assign free_s3  = !v_s3 || free_s4;
	assign free_s2  = !v_s2 || free_s3;
	assign free_s1  = !v_s1 || free_s2;
	assign in_ready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (free_s1) v_s1 <= in_valid;
			if (free_s2) v_s2 <= v_s1;
			if (free_s3) v_s3 <= v_s2;
			if (free_s4) v_s4 <= v_s3;
			if (free_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1) begin
			neg_s1 <= value[VALUE_W-1];
			// Unsigned negation also gives the right magnitude for the most negative value.
			mag_s1 <= value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
		end
		if (free_s2) begin
			neg_s2 <= neg_s1;
			bcd_s2 <= dd_step8('0, mag_s1[VALUE_W-1 -: 8]);
			low_s2 <= mag_s1[LOW2_W-1:0];
		end
		if (free_s3) begin
			neg_s3 <= neg_s2;
			bcd_s3 <= dd_step8(bcd_s2, low_s2[LOW2_W-1 -: 8]);
			low_s3 <= low_s2[LOW3_W-1:0];
		end
		if (free_s4) begin
			neg_s4 <= neg_s3;
			bcd_s4 <= dd_step8(bcd_s3, low_s3[LOW3_W-1 -: 8]);
			low_s4 <= low_s3[LOW4_W-1:0];
		end
		if (free_s5) begin
			neg_s5 <= neg_s4;
			bcd_s5 <= dd_step8(bcd_s4, low_s4);
		end
	end

	// Character emitter: the sign first if any, then digits from the top nonzero one down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			sign_q <= neg_s5;
			idx_q  <= top_digit(bcd_s5);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (out_fire) begin
			if (sign_q)
				sign_q <= 1'b0;
			else
				idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			digits_q <= bcd_s5;
	end

	assign out_valid = busy_q;
	assign character = sign_q ? CHAR_MINUS
	                          : (CHAR_ZERO + {{(CHAR_W-4){1'b0}}, digits_q[4*idx_q +: 4]});
	assign last      = !sign_q && (idx_q == '0);

endmodule

/* rtl/sitda_checker.sv */
// Port checker for the integer to decimal text block, bound to the top level.
`include "signed_int_to_decimal_ascii_assert.svh"

module sitda_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic signed [sitda_pkg::VALUE_W-1:0] value,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic        [sitda_pkg::CHAR_W-1:0]  character,
	input logic                                 last
);
	import sitda_pkg::*;

	logic mid_q;
	logic unused_in;

	assign unused_in = in_valid ^ in_ready ^ (^value);

	// Set while a text has started and its last character has not been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			mid_q <= !last;
		end
	end

	`SITDA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
	`SITDA_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(character) && $stable(last))
	`SITDA_ASSERT(a_minus_first, out_valid && mid_q |-> (character != CHAR_MINUS))
	`SITDA_ASSERT(a_minus_not_last, out_valid && (character == CHAR_MINUS) |-> !last)
	`SITDA_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid)

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

/* verif/signed_int_to_decimal_ascii_checker.sv */
// Checker that predicts and compares the decimal text of every accepted request.
module signed_int_to_decimal_ascii_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic        [sitda_pkg::CHAR_W-1:0]  character,
	input  logic                                 last,
	output int                                   fail_count,
	output int                                   pending
);

	typedef struct packed {
		logic [sitda_pkg::CHAR_W-1:0] ch;
		logic                         is_last;
	} text_char_t;

	text_char_t expected_text[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Decimal text of one value: optional minus sign, then digits from the most significant.
	task automatic queue_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] v);
		logic [sitda_pkg::VALUE_W-1:0] mag;
		logic [3:0]                    digs[sitda_pkg::NUM_DIGITS];
		int                            nd;
		text_char_t                    tc;
		// The magnitude is taken modulo 2**32, so the most negative value yields 2147483648.
		mag = v[sitda_pkg::VALUE_W-1] ? (32'd0 - v) : v;
		nd = 0;
		do begin
			digs[nd] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			nd++;
		end while (mag != 0);
		if (v[sitda_pkg::VALUE_W-1]) begin
			tc.ch = sitda_pkg::CHAR_MINUS;
			tc.is_last = 1'b0;
			expected_text.push_back(tc);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			tc.ch = sitda_pkg::CHAR_ZERO + 8'(digs[i]);
			tc.is_last = (i == 0);
			expected_text.push_back(tc);
		end
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				queue_decimal_text(value);
			if (out_valid && out_ready) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("character 0x%02h with no request waiting",
						character));
				end else begin
					want = expected_text.pop_front();
					if (character !== want.ch)
						report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
							character, want.ch));
					if (last !== want.is_last)
						report_mismatch($sformatf("last %b, expected %b on character 0x%02h",
							last, want.is_last, want.ch));
				end
			end
			pending <= expected_text.size();
		end
	end

endmodule

/* verif/tb_signed_int_to_decimal_ascii.sv */
// Testbench top for the integer to decimal text block: stimulus, flow control and verdict.
module tb_signed_int_to_decimal_ascii;

	localparam int PHASE_ITEMS = 105;
	localparam int NUM_PHASES  = 4;
	localparam int CYCLE_LIMIT = 300000;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [sitda_pkg::VALUE_W-1:0] value;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic        [sitda_pkg::CHAR_W-1:0]  character;
	logic                                 last;

	int fail_count;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	signed_int_to_decimal_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	signed_int_to_decimal_ascii_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_request(input logic [sitda_pkg::VALUE_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Holds off the sender until every character of every request has come out.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Mostly values of a random digit count so that short and long texts are both common.
	function automatic logic [sitda_pkg::VALUE_W-1:0] random_value();
		int unsigned       nd;
		longint unsigned   lo;
		longint unsigned   hi;
		longint unsigned   mag;
		logic              neg;
		if ($urandom_range(9) < 3)
			return $urandom;
		nd = $urandom_range(1, 10);
		neg = 1'($urandom_range(1));
		lo = 1;
		repeat (nd - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (nd == 10)
			hi = neg ? 64'd2147483648 : 64'd2147483647;
		if (nd == 1)
			lo = 0;
		mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
		return neg ? 32'(-mag) : 32'(mag);
	endfunction

	initial begin
		static logic [sitda_pkg::VALUE_W-1:0] directed[] = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, 32'sd99, 32'sd100,
			-32'sd100, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
			32'sd1000000000, 32'sd999999999, -32'sd1000000000, 32'sd1999999999,
			32'h5555_5555, 32'hAAAA_AAAA, 32'sd123456789, -32'sd987654321,
			32'sd7, -32'sd42
		};
		static int phase_idle[NUM_PHASES]  = '{0, 50, 0, 26};
		static int phase_stall[NUM_PHASES] = '{0, 0, 50, 26};

		in_valid = 1'b0;
		value = '0;
		// Applied after every process waits, so the falling reset is always seen.
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i]);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain();
				send_request(random_value());
			end
			drain();
		end

		stall_pct = 0;
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
